FILE: rtl/ias_pkg.sv
// Shared types and constants for the integer array sorter.
`timescale 1ns / 1ps
`default_nettype none

package ias_pkg;

    localparam int DATA_W       = 32;
    localparam int CAPACITY_DEF = 64;

    typedef enum logic {
        ST_LOAD,
        ST_DRAIN
    } t_state;

    // What one cell shows to its neighbors.
    typedef struct packed {
        logic signed [DATA_W-1:0] value;
        logic                     valid;
        logic                     gt;
    } t_cell_link;

    // Commands broadcast to every cell of the chain.
    typedef struct packed {
        logic insert;
        logic drain;
    } t_cell_ctrl;

endpackage

`default_nettype wire

FILE: rtl/ias_cell.sv
// One cell of the insertion chain: holds a single element and its valid bit.
`timescale 1ns / 1ps
`default_nettype none

module ias_cell (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire ias_pkg::t_cell_ctrl                  i_ctrl,
    input  wire logic signed [ias_pkg::DATA_W-1:0]    i_value,
    input  wire ias_pkg::t_cell_link                  i_left,
    input  wire ias_pkg::t_cell_link                  i_right,
    output ias_pkg::t_cell_link                       o_link
);

    logic signed [ias_pkg::DATA_W-1:0] r_value;
    logic                              r_valid;
    logic                              w_gt;
    logic                              w_take;

    // The cell moves right when the new value sorts before it, or it is
    // the first empty cell.
    assign w_gt   = r_valid && (r_value > i_value);
    assign w_take = w_gt || (!r_valid && i_left.valid);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_ctrl.drain) begin
            r_valid <= i_right.valid;
        end else if (i_ctrl.insert && w_take) begin
            r_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.drain) begin
            r_value <= i_right.value;
        end else if (i_ctrl.insert && w_take) begin
            r_value <= i_left.gt ? i_left.value : i_value;
        end
    end

    assign o_link.value = r_value;
    assign o_link.valid = r_valid;
    assign o_link.gt    = w_gt;

endmodule

`default_nettype wire

FILE: rtl/integer_array_sorter.sv
// Top level of the integer array sorter: insertion cell chain and stream ports.
`timescale 1ns / 1ps
`default_nettype none

// Integer array sorter. Signed 32-bit values arrive one item per cycle on the
// slave stream; tlast closes a set. Each value is inserted into a chain of
// CAPACITY identical cells that always holds the stored values in ascending
// order, so loading runs at one item per cycle with no sort phase afterward.
// Once the closing item has been taken, the input stalls and the set is
// emitted from the head cell, smallest first, one item per cycle while the
// master side is ready; the whole chain shifts toward the head on every
// emitted item. Values that arrive when all cells are full (the closing one
// included) are dropped, and every output item of that set carries tuser = 1.
// The output tlast marks the largest value. The chain is empty again after
// the last output item, and the next set can load in the following cycle.

module integer_array_sorter #(
    parameter int CAPACITY = ias_pkg::CAPACITY_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    // Slave side: tdata = value[31:0]; tlast = last.
    input  wire logic                          i_s_tvalid,
    output logic                               o_s_tready,
    input  wire logic [ias_pkg::DATA_W-1:0]    i_s_tdata,
    input  wire logic                          i_s_tlast,
    // Master side: tdata = sorted_value[31:0]; tlast = last_res;
    // tuser = overflow[0].
    output logic                               o_m_tvalid,
    input  wire logic                          i_m_tready,
    output logic [ias_pkg::DATA_W-1:0]         o_m_tdata,
    output logic                               o_m_tlast,
    output logic                               o_m_tuser
);

    ias_pkg::t_state     r_state;
    ias_pkg::t_state     n_state;
    logic                r_overflow;
    logic                n_overflow;
    ias_pkg::t_cell_ctrl w_ctrl;
    ias_pkg::t_cell_link w_link [CAPACITY];
    ias_pkg::t_cell_link w_head;
    ias_pkg::t_cell_link w_tail;
    logic [CAPACITY-1:0] w_valid;
    logic                w_in_acc;
    logic                w_out_acc;
    logic                w_full;

    assign w_in_acc  = i_s_tvalid && o_s_tready;
    assign w_out_acc = o_m_tvalid && i_m_tready;
    assign w_full    = w_link[CAPACITY-1].valid;

    // The head cell sees the incoming value as its left neighbor; the tail
    // cell pulls in an empty slot while the chain drains.
    assign w_head.value = $signed(i_s_tdata);
    assign w_head.valid = 1'b1;
    assign w_head.gt    = 1'b0;
    assign w_tail.value = '0;
    assign w_tail.valid = 1'b0;
    assign w_tail.gt    = 1'b0;

    assign w_ctrl.insert = w_in_acc && !w_full;
    assign w_ctrl.drain  = w_out_acc;

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        ias_pkg::t_cell_link w_left;
        ias_pkg::t_cell_link w_right;

        if (g == 0) begin : g_first
            assign w_left = w_head;
        end else begin : g_mid_l
            assign w_left = w_link[g-1];
        end

        if (g == CAPACITY - 1) begin : g_last
            assign w_right = w_tail;
        end else begin : g_mid_r
            assign w_right = w_link[g+1];
        end

        ias_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctrl  (w_ctrl),
            .i_value ($signed(i_s_tdata)),
            .i_left  (w_left),
            .i_right (w_right),
            .o_link  (w_link[g])
        );

        assign w_valid[g] = w_link[g].valid;
    end

    // Next state: the closing item starts the drain; the final output item
    // ends it.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ias_pkg::ST_LOAD: begin
                if (w_in_acc && i_s_tlast) begin
                    n_state = ias_pkg::ST_DRAIN;
                end
            end
            ias_pkg::ST_DRAIN: begin
                if (w_out_acc && o_m_tlast) begin
                    n_state = ias_pkg::ST_LOAD;
                end
            end
            default: n_state = ias_pkg::ST_LOAD;
        endcase
    end

    // Outputs: the head cell is the output register.
    always_comb begin
        o_s_tready = 1'b0;
        o_m_tvalid = 1'b0;
        unique case (r_state)
            ias_pkg::ST_LOAD: begin
                o_s_tready = 1'b1;
            end
            ias_pkg::ST_DRAIN: begin
                o_m_tvalid = w_link[0].valid;
            end
            default: begin
                o_s_tready = 1'b0;
            end
        endcase
    end

    assign o_m_tdata = w_link[0].value;
    assign o_m_tlast = !w_link[1].valid;
    assign o_m_tuser = r_overflow;

    // The overflow flag is raised by any dropped value and cleared once the
    // set has been fully delivered.
    always_comb begin
        n_overflow = r_overflow;
        if (w_in_acc && w_full) begin
            n_overflow = 1'b1;
        end else if (w_out_acc && o_m_tlast) begin
            n_overflow = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ias_pkg::ST_LOAD;
            r_overflow <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_overflow <= n_overflow;
        end
    end

`ifndef ASSERT_OFF
    localparam logic [CAPACITY-1:0] ValidOne = {{(CAPACITY-1){1'b0}}, 1'b1};

    // Occupied cells always form a contiguous run starting at the head.
    a_valid_prefix: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_valid & (w_valid + ValidOne)) == '0)
        else $error("cell chain has a gap in its occupied cells");

    // Adjacent output items leave in ascending order.
    a_ordered: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !o_m_tlast) |-> (w_link[0].value <= w_link[1].value))
        else $error("head cells out of order");

    // After the final item of a set the chain is empty and loading resumes.
    a_set_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_out_acc && o_m_tlast) |=> (o_s_tready && !o_m_tvalid && w_valid == '0))
        else $error("chain not empty after the final output item");

    // A closing item always leaves at least one value to emit.
    a_close_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && i_s_tlast) |=> o_m_tvalid)
        else $error("closed set has nothing to emit");
`endif

endmodule

`default_nettype wire

FILE: sim/tb.sv
// Self-checking testbench for the integer array sorter: stream stimulus and sorted-output check.
`timescale 1ns / 1ps

module tb;

    localparam int SORT_DEPTH  = ias_pkg::CAPACITY_DEF;
    localparam int CYCLE_LIMIT = 400000;
    localparam int PRINT_LIMIT = 20;

    // One sorted item as the master side should present it.
    typedef struct packed {
        logic [ias_pkg::DATA_W-1:0] value;
        logic                       last;
        logic                       ovf;
    } t_sorted_item;

    // Tracks the set being loaded and the sorted items still owed by the block.
    class sort_scoreboard;
        logic signed [ias_pkg::DATA_W-1:0] held[$];
        bit                                dropped;
        t_sorted_item                      owed[$];
        int                                errors;
        int                                items_in;
        int                                items_out;
        int                                sets_closed;
        int                                overflow_sets;

        task report(input string msg);
            if (errors < PRINT_LIMIT) begin
                $display("tb: mismatch at %0t: %s", $realtime, msg);
            end
            errors++;
        endtask

        // Insert an accepted value in ascending order; on the closing item
        // the whole set becomes owed, then the set state clears.
        function void note_input(input logic signed [ias_pkg::DATA_W-1:0] v,
                                 input logic is_last);
            int           pos;
            t_sorted_item exp_item;
            items_in++;
            if (held.size() >= SORT_DEPTH) begin
                dropped = 1'b1;
            end else begin
                pos = held.size();
                while (pos > 0 && held[pos-1] > v) pos--;
                held.insert(pos, v);
            end
            if (is_last) begin
                for (int k = 0; k < held.size(); k++) begin
                    exp_item.value = held[k];
                    exp_item.last  = (k == held.size() - 1);
                    exp_item.ovf   = dropped;
                    owed.push_back(exp_item);
                end
                sets_closed++;
                if (dropped) overflow_sets++;
                held.delete();
                dropped = 1'b0;
            end
        endfunction

        task check_result(input logic [ias_pkg::DATA_W-1:0] d, input logic l,
                          input logic u);
            t_sorted_item exp_item;
            items_out++;
            if (owed.size() == 0) begin
                report($sformatf("unexpected item value=%0d last=%0b ovf=%0b",
                                 $signed(d), l, u));
            end else begin
                exp_item = owed.pop_front();
                if (d !== exp_item.value)
                    report($sformatf("value %0d, expected %0d", $signed(d),
                                     $signed(exp_item.value)));
                if (l !== exp_item.last)
                    report($sformatf("last %0b, expected %0b", l, exp_item.last));
                if (u !== exp_item.ovf)
                    report($sformatf("overflow %0b, expected %0b", u, exp_item.ovf));
            end
        endtask
    endclass

    logic                       i_clk;
    logic                       i_rst_n;
    logic                       i_s_tvalid;
    logic                       o_s_tready;
    logic [ias_pkg::DATA_W-1:0] i_s_tdata;   // value[31:0]
    logic                       i_s_tlast;   // last
    logic                       o_m_tvalid;
    logic                       i_m_tready;
    logic [ias_pkg::DATA_W-1:0] o_m_tdata;   // sorted_value[31:0]
    logic                       o_m_tlast;   // last_res
    logic                       o_m_tuser;   // overflow[0]

    sort_scoreboard sb = new;
    int             send_idle_pct;
    int             recv_stall_pct;
    int             cycles;

    integer_array_sorter uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tlast  (i_s_tlast),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast),
        .o_m_tuser  (o_m_tuser)
    );

    initial i_clk = 1'b0;
    always #1 i_clk = ~i_clk;

    // Receiver: ready is redrawn at every falling edge.
    always @(negedge i_clk) begin
        i_m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Result monitor and watchdog.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            sb.check_result(o_m_tdata, o_m_tlast, o_m_tuser);
        end
        if (cycles > CYCLE_LIMIT) begin
            $display("tb: timeout after %0d cycles", cycles);
            $display("tb: FAIL");
            $finish;
        end
    end

    // Called just after a falling edge; returns just after a falling edge.
    task send_item(input logic signed [ias_pkg::DATA_W-1:0] v, input logic is_last);
        while ($urandom_range(99) < send_idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= v;
        i_s_tlast  <= is_last;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        sb.note_input(v, is_last);
        @(negedge i_clk);
    endtask

    task send_set(input logic signed [ias_pkg::DATA_W-1:0] vals[$]);
        for (int i = 0; i < vals.size(); i++) begin
            send_item(vals[i], i == vals.size() - 1);
        end
    endtask

    // Hold the sender off until the block has delivered everything owed.
    task drain_results;
        i_s_tvalid <= 1'b0;
        while (sb.owed.size() != 0) @(negedge i_clk);
    endtask

    // Mix of full-range values, a narrow band that forces duplicates and
    // sign changes, and the extremes of the signed range.
    function logic signed [ias_pkg::DATA_W-1:0] rand_value(input int flavor);
        int pick;
        pick = (flavor == 3) ? $urandom_range(2) : flavor;
        case (pick)
            0: rand_value = $urandom;
            1: rand_value = $signed($urandom_range(8)) - 4;
            default: begin
                case ($urandom_range(4))
                    0: rand_value = 32'sh8000_0000;
                    1: rand_value = 32'sh7FFF_FFFF;
                    2: rand_value = 0;
                    3: rand_value = -1;
                    default: rand_value = 1;
                endcase
            end
        endcase
    endfunction

    task send_random_set(input int n);
        logic signed [ias_pkg::DATA_W-1:0] vals[$];
        int                                flavor;
        flavor = $urandom_range(3);
        for (int i = 0; i < n; i++) vals.push_back(rand_value(flavor));
        send_set(vals);
    endtask

    initial begin
        int phase_start;

        i_rst_n        = 1'b0;
        i_s_tvalid     = 1'b0;
        i_s_tdata      = '0;
        i_s_tlast      = 1'b0;
        i_m_tready     = 1'b0;
        cycles         = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed sets: single extremes, mixed signs with duplicates,
        // all-equal values, and both presorted orders.
        send_set('{32'sh8000_0000});
        send_set('{32'sh7FFF_FFFF});
        send_set('{5, -5, 0, 32'sh7FFF_FFFF, 32'sh8000_0000, -1, 1, 0});
        send_set('{3, 3, 3});
        send_set('{4, 3, 2, 1});
        send_set('{1, 2, 3, 4});

        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 78; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 78; end
                default: begin send_idle_pct = 27; recv_stall_pct = 27; end
            endcase
            // One overrun set fills the chain, then loses a value and the
            // closing item.
            if (phase == 2) send_random_set(SORT_DEPTH + 2);
            phase_start = sb.items_in;
            while (sb.items_in - phase_start < 16) begin
                send_random_set($urandom_range(1, 12));
                if ($urandom_range(9) == 0) drain_results;
            end
            drain_results;
        end

        i_s_tvalid <= 1'b0;
        while (sb.owed.size() != 0) @(posedge i_clk);
        repeat (2 * SORT_DEPTH + 16) @(posedge i_clk);

        $display("tb: %0d items in %0d sets (%0d overflowed), %0d sorted items checked",
                 sb.items_in, sb.sets_closed, sb.overflow_sets, sb.items_out);
        $display("tb: phases covered free flow, sender gaps, receiver stalls and both");
        if (sb.errors == 0 && sb.owed.size() == 0) begin
            $display("tb: PASS");
        end else begin
            $display("tb: FAIL");
        end
        $finish;
    end

endmodule
